// ===== design/zone_range_to_point_core_macros.svh =====
// ----------------------------------------------------------------------------
// zone_range_to_point_core assertion macros
// Shared concurrent assertion forms, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef ZONE_RANGE_TO_POINT_CORE_MACROS_SVH
`define ZONE_RANGE_TO_POINT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ZRP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ZRP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/zrp_pkg.sv =====
// ----------------------------------------------------------------------------
// zrp_pkg
// Shared widths, register indexes, word types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package zrp_pkg;

  localparam int unsigned FOV_W      = 16;
  localparam int unsigned CNT_CFG_W  = 5;
  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HFOV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VFOV    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd3;

  // Angle magnitude clamp, just below pi/2 in Q2.14
  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 16'd25735;
  // CORDIC start vector length, Q2.30 scale / 2
  localparam logic signed [31:0] CORDIC_START = 32'sd536870912;

  typedef struct packed {
    logic [FOV_W-1:0]     fov_h;
    logic [FOV_W-1:0]     fov_v;
    logic [CNT_CFG_W-1:0] columns;
    logic [CNT_CFG_W-1:0] rows;
  } zrp_cfg_t;

  // Classified word passed from front to back
  typedef struct packed {
    logic [RANGE_W-1:0]        range_sample;
    logic signed [ANGLE_W-1:0] col_angle;
    logic signed [ANGLE_W-1:0] row_angle;
    logic                      frame_end;
  } zrp_item_t;

  // atan(2^-k) in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000007;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000000;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== design/zrp_udiv.sv =====
// ----------------------------------------------------------------------------
// zrp_udiv
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module zrp_udiv #(
  parameter int unsigned NUM_W = 47,
  parameter int unsigned DEN_W = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    fits     = (trial >= {1'b0, den_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/zrp_front.sv =====
// ----------------------------------------------------------------------------
// zrp_front
// Accepts range words, tracks the zone counters and works out both zone
// angles with two iterative dividers before queueing the word.
// ----------------------------------------------------------------------------
module zrp_front #(
  parameter int unsigned MAX_SIDE = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  zrp_pkg::zrp_cfg_t            cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [zrp_pkg::RANGE_W-1:0]  in_range_sample,
  output logic                         q_push,
  output zrp_pkg::zrp_item_t           q_push_item,
  input  logic                         q_full
);

  localparam int unsigned IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SIDE + 1);
  localparam int unsigned CMP_W  = (CNT_W > zrp_pkg::CNT_CFG_W) ? CNT_W : zrp_pkg::CNT_CFG_W;
  localparam int unsigned PROD_W = CNT_W + zrp_pkg::FOV_W;
  localparam int unsigned DEN_W  = CNT_W + 1;

  typedef enum logic [1:0] {F_IDLE, F_START, F_DIV, F_PUSH} state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   col_idx_r, col_idx_nxt;
  logic [IDX_W-1:0]   row_idx_r, row_idx_nxt;
  zrp_pkg::zrp_item_t item_r, item_nxt;
  logic [PROD_W-1:0]  col_prod_r, col_prod_nxt, row_prod_r, row_prod_nxt;
  logic [DEN_W-1:0]   col_den_r, col_den_nxt, row_den_r, row_den_nxt;
  logic               col_neg_r, col_neg_nxt, row_neg_r, row_neg_nxt;

  logic [CNT_W-1:0]   n_col, n_row;
  logic [CNT_W:0]     col_off, row_off;
  logic               last_col, last_row;
  logic               div_start;
  logic               col_done, row_done;
  logic [PROD_W-1:0]  col_quo, row_quo;

  // Zero counts as one, large counts saturate
  function automatic logic [CNT_W-1:0] eff_count(input logic [zrp_pkg::CNT_CFG_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w == '0) begin
      return CNT_W'(1);
    end else if (w > CMP_W'(MAX_SIDE)) begin
      return CNT_W'(MAX_SIDE);
    end
    return CNT_W'(w);
  endfunction

  // Sign and magnitude of 2i-n+1, index clamped to the last zone
  function automatic logic [CNT_W:0] zone_offset(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n);
    logic [CMP_W-1:0]        lim;
    logic [CNT_W-1:0]        e;
    logic signed [CNT_W+1:0] off;
    logic [CNT_W+1:0]        mag;
    lim = CMP_W'(n) - CMP_W'(1);
    e   = (CMP_W'(idx) >= lim) ? CNT_W'(lim) : CNT_W'(idx);
    off = $signed({1'b0, e, 1'b0}) - $signed({2'b00, n}) + $signed((CNT_W+2)'(1));
    mag = off[CNT_W+1] ? (~off + 1'b1) : off;
    return {off[CNT_W+1], mag[CNT_W-1:0]};
  endfunction

  // Clamp the quotient and put the sign back
  function automatic logic signed [zrp_pkg::ANGLE_W-1:0] make_angle(
      input logic [PROD_W-1:0] q, input logic neg);
    logic [zrp_pkg::ANGLE_W-1:0] m;
    m = (q > PROD_W'(zrp_pkg::ANGLE_LIMIT)) ? zrp_pkg::ANGLE_LIMIT : q[zrp_pkg::ANGLE_W-1:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // Classify the current zone
  assign n_col    = eff_count(cfg.columns);
  assign n_row    = eff_count(cfg.rows);
  assign col_off  = zone_offset(col_idx_r, n_col);
  assign row_off  = zone_offset(row_idx_r, n_row);
  assign last_col = (CMP_W'(col_idx_r) >= (CMP_W'(n_col) - CMP_W'(1)));
  assign last_row = (CMP_W'(row_idx_r) >= (CMP_W'(n_row) - CMP_W'(1)));

  always_comb begin
    state_nxt    = state_r;
    col_idx_nxt  = col_idx_r;
    row_idx_nxt  = row_idx_r;
    item_nxt     = item_r;
    col_prod_nxt = col_prod_r;
    row_prod_nxt = row_prod_r;
    col_den_nxt  = col_den_r;
    row_den_nxt  = row_den_r;
    col_neg_nxt  = col_neg_r;
    row_neg_nxt  = row_neg_r;
    in_ready     = (state_r == F_IDLE);
    div_start    = (state_r == F_START);
    q_push       = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          item_nxt.range_sample = in_range_sample;
          item_nxt.frame_end    = last_col && last_row;
          col_neg_nxt  = col_off[CNT_W];
          row_neg_nxt  = row_off[CNT_W];
          col_prod_nxt = PROD_W'(col_off[CNT_W-1:0]) * PROD_W'(cfg.fov_h);
          row_prod_nxt = PROD_W'(row_off[CNT_W-1:0]) * PROD_W'(cfg.fov_v);
          col_den_nxt  = {n_col, 1'b0};
          row_den_nxt  = {n_row, 1'b0};
          // Advance the zone counters: columns wrap at each row end, rows at the frame end
          if (last_col) begin
            col_idx_nxt = '0;
            if (last_row) begin
              row_idx_nxt = '0;
            end else begin
              row_idx_nxt = row_idx_r + 1'b1;
            end
          end else begin
            col_idx_nxt = col_idx_r + 1'b1;
          end
          state_nxt = F_START;
        end
      end
      F_START: begin
        state_nxt = F_DIV;
      end
      F_DIV: begin
        if (col_done && row_done) begin
          item_nxt.col_angle = make_angle(col_quo, col_neg_r);
          item_nxt.row_angle = make_angle(row_quo, row_neg_r);
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        q_push = !q_full;
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      col_idx_r <= '0;
      row_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      col_idx_r <= col_idx_nxt;
      row_idx_r <= row_idx_nxt;
    end
  end

  // Word payload, no reset
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    col_prod_r <= col_prod_nxt;
    row_prod_r <= row_prod_nxt;
    col_den_r  <= col_den_nxt;
    row_den_r  <= row_den_nxt;
    col_neg_r  <= col_neg_nxt;
    row_neg_r  <= row_neg_nxt;
  end

  zrp_udiv #(
    .NUM_W (PROD_W),
    .DEN_W (DEN_W)
  ) u_col_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (col_prod_r),
    .divisor  (col_den_r),
    .done     (col_done),
    .quotient (col_quo)
  );

  zrp_udiv #(
    .NUM_W (PROD_W),
    .DEN_W (DEN_W)
  ) u_row_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (row_prod_r),
    .divisor  (row_den_r),
    .done     (row_done),
    .quotient (row_quo)
  );

  assign q_push_item = item_r;

endmodule

// ===== design/zrp_queue.sv =====
// ----------------------------------------------------------------------------
// zrp_queue
// Two-entry word queue between the front and the back.
// ----------------------------------------------------------------------------
module zrp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  zrp_pkg::zrp_item_t push_item,
  output logic               full,
  input  logic               pop,
  output zrp_pkg::zrp_item_t pop_item,
  output logic               empty
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  zrp_pkg::zrp_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        2'b00,
        2'b11:   count_r <= count_r;
      endcase
    end
  end

  // Hold word storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/zrp_back.sv =====
// ----------------------------------------------------------------------------
// zrp_back
// Two CORDIC lanes (column and row) give sin/cos, then range*sin is divided
// by cos, saturated and placed in the output register.
// ----------------------------------------------------------------------------
module zrp_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  zrp_pkg::zrp_item_t                  q_pop_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [zrp_pkg::RANGE_W-1:0]         out_point_x,
  output logic signed [zrp_pkg::COORD_W-1:0]  out_point_y,
  output logic signed [zrp_pkg::COORD_W-1:0]  out_point_z,
  output logic                                out_frame_end
);

  localparam int unsigned KW    = $clog2(CORDIC_STEPS);
  localparam int unsigned VEC_W = 32;
  localparam int unsigned XD_W  = VEC_W - 1;
  localparam int unsigned MAG_W = zrp_pkg::RANGE_W + XD_W;
  localparam int unsigned Z_W   = 34;
  localparam int unsigned LANES = 2;

  typedef enum logic [2:0] {B_IDLE, B_ROT, B_MUL, B_START, B_DIV, B_OUT} state_t;

  state_t                      state_r, state_nxt;
  logic [KW-1:0]               k_r, k_nxt;
  logic [zrp_pkg::RANGE_W-1:0] range_r, range_nxt;
  logic                        last_r, last_nxt;
  logic signed [VEC_W-1:0]     x_r [LANES], x_nxt [LANES];
  logic signed [VEC_W-1:0]     y_r [LANES], y_nxt [LANES];
  logic signed [Z_W-1:0]       z_r [LANES], z_nxt [LANES];
  logic [MAG_W-1:0]            mag_r [LANES], mag_nxt [LANES];
  logic [XD_W-1:0]             den_r [LANES], den_nxt [LANES];
  logic                        neg_r [LANES], neg_nxt [LANES];

  logic                        out_valid_r, out_valid_nxt;
  logic [zrp_pkg::RANGE_W-1:0] out_x_r, out_x_nxt;
  logic [zrp_pkg::COORD_W-1:0] out_y_r, out_y_nxt, out_z_r, out_z_nxt;
  logic                        out_end_r, out_end_nxt;

  logic signed [zrp_pkg::ANGLE_W-1:0] lane_angle [LANES];
  logic signed [VEC_W-1:0]            dx [LANES], dy [LANES];
  logic [XD_W-1:0]                    ymag [LANES], xden [LANES];
  logic                               ypos [LANES];
  logic signed [Z_W-1:0]              atan_k;
  logic                               div_start;
  logic                               div_done [LANES];
  logic [MAG_W-1:0]                   quo [LANES];

  // Truncated quotient magnitude to saturated signed 32-bit result
  function automatic logic [zrp_pkg::COORD_W-1:0] saturate(input logic [MAG_W-1:0] m,
                                                           input logic neg);
    logic big;
    big = |m[MAG_W-1:zrp_pkg::COORD_W-1];
    if (neg) begin
      return big ? {1'b1, {(zrp_pkg::COORD_W-1){1'b0}}} : (~m[zrp_pkg::COORD_W-1:0] + 1'b1);
    end
    return big ? {1'b0, {(zrp_pkg::COORD_W-1){1'b1}}} : m[zrp_pkg::COORD_W-1:0];
  endfunction

  assign lane_angle[0] = q_pop_item.col_angle;
  assign lane_angle[1] = q_pop_item.row_angle;

  // Per-lane shift terms and post-rotation operands
  always_comb begin
    atan_k = $signed({2'b00, zrp_pkg::atan_q30(5'(k_r))});
    for (int i = 0; i < LANES; i++) begin
      dx[i]   = y_r[i] >>> k_r;
      dy[i]   = x_r[i] >>> k_r;
      ymag[i] = y_r[i][VEC_W-1] ? XD_W'(-y_r[i]) : XD_W'(y_r[i]);
      xden[i] = (x_r[i] > 0) ? x_r[i][XD_W-1:0] : XD_W'(1);
      ypos[i] = (y_r[i] > 0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    range_nxt     = range_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_end_nxt   = out_end_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      x_nxt[i]   = x_r[i];
      y_nxt[i]   = y_r[i];
      z_nxt[i]   = z_r[i];
      mag_nxt[i] = mag_r[i];
      den_nxt[i] = den_r[i];
      neg_nxt[i] = neg_r[i];
    end
    // Drop the output word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          range_nxt = q_pop_item.range_sample;
          last_nxt  = q_pop_item.frame_end;
          for (int i = 0; i < LANES; i++) begin
            x_nxt[i] = zrp_pkg::CORDIC_START;
            y_nxt[i] = '0;
            z_nxt[i] = $signed({{2{lane_angle[i][zrp_pkg::ANGLE_W-1]}}, lane_angle[i], 16'h0000});
          end
          k_nxt     = '0;
          state_nxt = B_ROT;
        end
      end
      B_ROT: begin
        // One micro-rotation per cycle
        for (int i = 0; i < LANES; i++) begin
          if (z_r[i] >= 0) begin
            x_nxt[i] = x_r[i] - dx[i];
            y_nxt[i] = y_r[i] + dy[i];
            z_nxt[i] = z_r[i] - atan_k;
          end else begin
            x_nxt[i] = x_r[i] + dx[i];
            y_nxt[i] = y_r[i] - dy[i];
            z_nxt[i] = z_r[i] + atan_k;
          end
        end
        k_nxt = k_r + 1'b1;
        if (k_r == KW'(CORDIC_STEPS - 1)) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        for (int i = 0; i < LANES; i++) begin
          mag_nxt[i] = MAG_W'(range_r) * MAG_W'(ymag[i]);
          den_nxt[i] = xden[i];
          neg_nxt[i] = ypos[i];
        end
        state_nxt = B_START;
      end
      B_START: begin
        div_start = 1'b1;
        state_nxt = B_DIV;
      end
      B_DIV: begin
        if (div_done[0] && div_done[1]) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        // Load the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_x_nxt     = range_r;
          out_y_nxt     = saturate(quo[0], neg_r[0]);
          out_z_nxt     = saturate(quo[1], neg_r[1]);
          out_end_nxt   = last_r;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and output payload, no reset
  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    range_r   <= range_nxt;
    last_r    <= last_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_z_r   <= out_z_nxt;
    out_end_r <= out_end_nxt;
    for (int i = 0; i < LANES; i++) begin
      x_r[i]   <= x_nxt[i];
      y_r[i]   <= y_nxt[i];
      z_r[i]   <= z_nxt[i];
      mag_r[i] <= mag_nxt[i];
      den_r[i] <= den_nxt[i];
      neg_r[i] <= neg_nxt[i];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_div
    zrp_udiv #(
      .NUM_W (MAG_W),
      .DEN_W (XD_W)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (mag_r[g]),
      .divisor  (den_r[g]),
      .done     (div_done[g]),
      .quotient (quo[g])
    );
  end

  assign out_valid     = out_valid_r;
  assign out_point_x   = out_x_r;
  assign out_point_y   = $signed(out_y_r);
  assign out_point_z   = $signed(out_z_r);
  assign out_frame_end = out_end_r;

endmodule

// ===== design/zone_range_to_point_core.sv =====
// ----------------------------------------------------------------------------
// zone_range_to_point_core
// Turns zone range words into 3D points: x = range, y and z from the
// tangents of the column and row angles, frame end flagged.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | in_range_sample
//  out     | out       | out_valid/out_ready  | out_point_x/y/z, out_frame_end
//
//  Front: takes one word at a time and waits on its two angle dividers.
//  Back: takes one word at a time, CORDIC then the 47-step divide of
//  range*sin by cos; the back is the slower side and sets the sustained rate.
//  A two-word queue sits between front and back; the output register lets
//  the back finish the next word while a result waits to be taken.
//  Reset is synchronous: zone counters clear, FOVs 0, columns and rows 8.
// ----------------------------------------------------------------------------
`include "zone_range_to_point_core_macros.svh"

module zone_range_to_point_core #(
  parameter int unsigned MAX_SIDE     = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [zrp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [zrp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [zrp_pkg::RANGE_W-1:0]         in_range_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [zrp_pkg::RANGE_W-1:0]         out_point_x,
  output logic signed [zrp_pkg::COORD_W-1:0]  out_point_y,
  output logic signed [zrp_pkg::COORD_W-1:0]  out_point_z,
  output logic                                out_frame_end
);

  zrp_pkg::zrp_cfg_t  cfg_r;
  logic               q_push, q_pop, q_full, q_empty;
  zrp_pkg::zrp_item_t q_push_item, q_pop_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fov_h   <= '0;
      cfg_r.fov_v   <= '0;
      cfg_r.columns <= zrp_pkg::CNT_CFG_W'(8);
      cfg_r.rows    <= zrp_pkg::CNT_CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        zrp_pkg::REG_HFOV:    cfg_r.fov_h   <= cfg_data;
        zrp_pkg::REG_VFOV:    cfg_r.fov_v   <= cfg_data;
        zrp_pkg::REG_COLUMNS: cfg_r.columns <= cfg_data[zrp_pkg::CNT_CFG_W-1:0];
        zrp_pkg::REG_ROWS:    cfg_r.rows    <= cfg_data[zrp_pkg::CNT_CFG_W-1:0];
      endcase
    end
  end

  zrp_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_range_sample (in_range_sample),
    .q_push          (q_push),
    .q_push_item     (q_push_item),
    .q_full          (q_full)
  );

  zrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_pop_item),
    .empty     (q_empty)
  );

  zrp_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_pop_item    (q_pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_point_z   (out_point_z),
    .out_frame_end (out_frame_end)
  );

  // Queue never overflows or underflows; front and back take one word at a time
  `ZRP_ASSERT_NOW(a_push_room, clk, rst_n, q_push, !q_full, "word pushed into a full queue")
  `ZRP_ASSERT_NOW(a_pop_data, clk, rst_n, q_pop, !q_empty, "word popped from an empty queue")
  `ZRP_ASSERT_NEXT(a_front_busy, clk, rst_n, in_valid && in_ready, !in_ready, "front took a second word")
  `ZRP_ASSERT_NEXT(a_back_busy, clk, rst_n, q_pop, !q_pop, "back popped two words in a row")

endmodule
